[hw/rtl/dpp_pkg.sv]
// Shared constants and types for the decimal pair parser and its arithmetic unit.
package dpp_pkg;

    // Width of the operands and of every arithmetic result.
    localparam int DATA_W = 32;
    // Iteration counter width for the bit-serial multiply and divide.
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // Parser phases within one line.
    typedef enum logic [2:0] {
        PH_AWAIT1,
        PH_SIGN1,
        PH_DIG1,
        PH_AWAIT2,
        PH_SIGN2,
        PH_DIG2,
        PH_TRAIL,
        PH_ERROR
    } t_phase;

    // Arithmetic sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_NEG,
        S_SETUP,
        S_ITER,
        S_DONE
    } t_alu_state;

endpackage

[hw/rtl/decimal_pair_parser_alu_unit.sv]
// Decimal pair parser with a bit-serial multiply and divide unit.
// Sequence: a character word is parsed in the cycle it is accepted; an end-of-line word gives
//   its result word on m_axis after the states S_NEG and S_SETUP, the 32 divide/multiply steps
//   of S_ITER, and S_DONE, which loads the output register once the output is no longer held.
// Throughput: one character word per cycle; after an end-of-line word the input is closed
//   until the shared serial unit has finished, which gives one quotient and product bit per cycle.
// Reset: i_rst_n is synchronous, active low; it returns the parser to the start of a line,
//   idles the arithmetic unit and empties the output register.
module decimal_pair_parser_alu_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] char_code
    input  logic         s_axis_tlast,  // end_of_line
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] sum, [63:32] difference, [95:64] product, [127:96] quotient,
    // [159:128] remainder
    output logic [159:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // [0] line_ok, [1] divide_by_zero
);
    import dpp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    // Parser state. It follows the characters of one line and keeps the first operand
    // and the digits of the number in progress.
    t_phase              r_phase,  n_phase;
    logic [DATA_W-1:0]   r_first,  n_first;
    logic [DATA_W-1:0]   r_acc,    n_acc;
    logic                r_neg,    n_neg;

    // Arithmetic sequencer state.
    t_alu_state          r_alu_state, n_alu_state;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic                r_out_valid, n_out_valid;

    // Operands captured at the end of a line.
    logic [DATA_W-1:0]   r_a,      n_a;
    logic [DATA_W-1:0]   r_b,      n_b;
    logic                r_b_neg,  n_b_neg;
    logic                r_ok,     n_ok;
    logic                r_zero,   n_zero;
    logic                r_sign_a, n_sign_a;
    logic                r_sign_b, n_sign_b;
    logic [DATA_W-1:0]   r_sum,    n_sum;
    logic [DATA_W-1:0]   r_diff,   n_diff;

    // Shift registers of the serial multiplier and the restoring divider.
    logic [DATA_W-1:0]   r_mul_a,  n_mul_a;
    logic [DATA_W-1:0]   r_mul_b,  n_mul_b;
    logic [DATA_W-1:0]   r_prod,   n_prod;
    logic [DATA_W-1:0]   r_div_q,  n_div_q;
    logic [DATA_W-1:0]   r_div_d,  n_div_d;
    logic [DATA_W-1:0]   r_rem,    n_rem;

    logic [159:0]        r_out_data, n_out_data;
    logic [1:0]          r_out_user, n_out_user;

    // Helper terms.
    logic                in_fire;
    logic                is_numeral;
    logic                is_blank;
    logic                is_sign;
    logic                is_minus;
    logic [DATA_W-1:0]   acc_next;
    logic [DATA_W-1:0]   signed_val;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_trial;
    logic [DATA_W-1:0]   quo_fix;
    logic [DATA_W-1:0]   rem_fix;
    logic                div_ok;

    assign s_axis_tready = (r_alu_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_comb begin
        is_numeral = (s_axis_tdata inside {[CHAR_0:CHAR_9]});
        is_blank = (s_axis_tdata == CHAR_SPACE) || (s_axis_tdata == CHAR_TAB);
        is_minus = (s_axis_tdata == CHAR_MINUS);
        is_sign  = is_minus || (s_axis_tdata == CHAR_PLUS);
        // Times ten as two shifted copies, plus the digit in the low nibble of its code.
        acc_next   = (r_acc << 3) + (r_acc << 1) + DATA_W'(s_axis_tdata[3:0]);
        signed_val = r_neg ? (DATA_W'(0) - r_acc) : r_acc;

        // One restoring divide step: bring down the next dividend bit, try a subtract.
        rem_shift = {r_rem, r_div_q[DATA_W-1]};
        rem_trial = rem_shift - {1'b0, r_div_d};

        // Signs go back on at the end; quotient wraps for the minimum over minus one.
        quo_fix = (r_sign_a ^ r_sign_b) ? (DATA_W'(0) - r_div_q) : r_div_q;
        rem_fix = r_sign_a ? (DATA_W'(0) - r_rem) : r_rem;
        div_ok  = r_ok && !r_zero;
    end

    // Next state of the parser and of the arithmetic sequencer.
    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_alu_state = r_alu_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_a         = r_a;
        n_b         = r_b;
        n_b_neg     = r_b_neg;
        n_ok        = r_ok;
        n_zero      = r_zero;
        n_sign_a    = r_sign_a;
        n_sign_b    = r_sign_b;
        n_sum       = r_sum;
        n_diff      = r_diff;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_prod      = r_prod;
        n_div_q     = r_div_q;
        n_div_d     = r_div_d;
        n_rem       = r_rem;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (in_fire && !s_axis_tlast) begin
            case (r_phase)
                PH_AWAIT1, PH_AWAIT2: begin
                    if (is_sign || is_numeral) begin
                        n_neg = is_minus;
                        if (is_sign) begin
                            n_acc   = '0;
                            n_phase = (r_phase == PH_AWAIT1) ? PH_SIGN1 : PH_SIGN2;
                        end else begin
                            n_acc   = DATA_W'(s_axis_tdata[3:0]);
                            n_phase = (r_phase == PH_AWAIT1) ? PH_DIG1 : PH_DIG2;
                        end
                    end else if (!is_blank) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_SIGN1, PH_SIGN2: begin
                    if (is_numeral) begin
                        n_acc   = acc_next;
                        n_phase = (r_phase == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DIG1: begin
                    if (is_numeral) begin
                        n_acc = acc_next;
                    end else if (is_blank) begin
                        n_first = signed_val;
                        n_phase = PH_AWAIT2;
                    end else if (is_sign) begin
                        // The second number starts right after the first one's digits.
                        n_first = signed_val;
                        n_acc   = '0;
                        n_neg   = is_minus;
                        n_phase = PH_SIGN2;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DIG2: begin
                    if (is_numeral) begin
                        n_acc = acc_next;
                    end else if (is_blank) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAIL: begin
                    if (!is_blank) begin
                        n_phase = PH_ERROR;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end

        case (r_alu_state)
            S_IDLE: begin
                if (in_fire && s_axis_tlast) begin
                    // Hand the line over to the arithmetic unit and start a new line.
                    n_a         = r_first;
                    n_b         = r_acc;
                    n_b_neg     = r_neg;
                    n_ok        = (r_phase == PH_DIG2) || (r_phase == PH_TRAIL);
                    n_phase     = PH_AWAIT1;
                    n_first     = '0;
                    n_acc       = '0;
                    n_neg       = 1'b0;
                    n_alu_state = S_NEG;
                end
            end
            S_NEG: begin
                n_b         = r_b_neg ? (DATA_W'(0) - r_b) : r_b;
                n_alu_state = S_SETUP;
            end
            S_SETUP: begin
                n_sum       = r_a + r_b;
                n_diff      = r_a - r_b;
                n_zero      = (r_b == '0);
                n_sign_a    = r_a[DATA_W-1];
                n_sign_b    = r_b[DATA_W-1];
                n_div_q     = r_a[DATA_W-1] ? (DATA_W'(0) - r_a) : r_a;
                n_div_d     = r_b[DATA_W-1] ? (DATA_W'(0) - r_b) : r_b;
                n_rem       = '0;
                n_mul_a     = r_a;
                n_mul_b     = r_b;
                n_prod      = '0;
                n_cnt       = CNT_LAST;
                n_alu_state = S_ITER;
            end
            S_ITER: begin
                if (r_mul_b[0]) begin
                    n_prod = r_prod + r_mul_a;
                end
                n_mul_a = r_mul_a << 1;
                n_mul_b = r_mul_b >> 1;
                if (!rem_trial[DATA_W]) begin
                    n_rem   = rem_trial[DATA_W-1:0];
                    n_div_q = {r_div_q[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem   = rem_shift[DATA_W-1:0];
                    n_div_q = {r_div_q[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_alu_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is free, then load it.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = {r_ok && r_zero, r_ok};
                    n_out_data  = {div_ok ? rem_fix : DATA_W'(0),
                                   div_ok ? quo_fix : DATA_W'(0),
                                   r_ok   ? r_prod  : DATA_W'(0),
                                   r_ok   ? r_diff  : DATA_W'(0),
                                   r_ok   ? r_sum   : DATA_W'(0)};
                    n_alu_state = S_IDLE;
                end
            end
            default: begin
                n_alu_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_AWAIT1;
            r_first     <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_alu_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_alu_state <= n_alu_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_a        <= n_a;
        r_b        <= n_b;
        r_b_neg    <= n_b_neg;
        r_ok       <= n_ok;
        r_zero     <= n_zero;
        r_sign_a   <= n_sign_a;
        r_sign_b   <= n_sign_b;
        r_sum      <= n_sum;
        r_diff     <= n_diff;
        r_mul_a    <= n_mul_a;
        r_mul_b    <= n_mul_b;
        r_prod     <= n_prod;
        r_div_q    <= n_div_q;
        r_div_d    <= n_div_d;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // An accepted end-of-line word always starts the arithmetic sequence.
    a_eol_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=> (r_alu_state == S_NEG))
        else $error("end-of-line word did not start the arithmetic unit");

    // The last serial step leads to the finishing state.
    a_iter_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alu_state == S_ITER && r_cnt == '0) |=> (r_alu_state == S_DONE))
        else $error("serial unit ran past its last step");

    // A divide-by-zero flag only comes with a well-formed line.
    a_dbz_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("divide-by-zero flagged on a malformed line");

    // A malformed line gives an all-zero result.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("malformed line gave nonzero results");

    // An accepted line ending returns the parser's state to the start of a line.
    a_parser_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=> (r_phase == PH_AWAIT1 && r_acc == '0 && !r_neg))
        else $error("parser not returned to line start");

endmodule
